// ----- design/pwvm_pkg.sv -----
package pwvm_pkg;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_NOTE_ON   = 3'd1;
    localparam logic [2:0] ACT_NOTE_OFF  = 3'd2;
    localparam logic [2:0] ACT_WAVE_WR   = 3'd3;
    localparam logic [2:0] ACT_STEP_WR   = 3'd4;

    localparam int NOTE_W  = 7;
    localparam int VOL_W   = 7;
    localparam int WAVE_W  = 16;
    localparam int DAC_W   = 12;
    localparam int TVAL_W  = 26;
    localparam int STEP_IN_W = 25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN,
        ST_STEPW
    } state_t;

    // control part of one voice
    typedef struct packed {
        logic              busy;
        logic [NOTE_W-1:0] note;
        logic [VOL_W-1:0]  vol;
    } voice_ctl_t;

endpackage

// ----- design/pwvm_cell.sv -----
module pwvm_cell #(
    parameter int PHASE_W = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  pwvm_pkg::voice_ctl_t ctl_in,
    input  logic [PHASE_W-1:0]  step_in,
    input  logic [PHASE_W-1:0]  phase_in,
    output pwvm_pkg::voice_ctl_t ctl_out,
    output logic [PHASE_W-1:0]  step_out,
    output logic [PHASE_W-1:0]  phase_out
);
    import pwvm_pkg::*;

    voice_ctl_t         ctl_reg;
    logic [PHASE_W-1:0] step_reg;
    logic [PHASE_W-1:0] phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            step_reg  <= '0;
            phase_reg <= '0;
        end
        else if (shift)
        begin
            ctl_reg   <= ctl_in;
            step_reg  <= step_in;
            phase_reg <= phase_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign step_out  = step_reg;
    assign phase_out = phase_reg;

endmodule

// ----- design/polyphonic_wavetable_voice_mixer.sv -----
// Channel   Dir  Fields (tdata, low bit up)
// s_axis    in   action[2:0] note_number[9:3] velocity[16:10] table_index[28:17]
//                table_value[54:29], zero pad to 56
// m_axis    out  dac_sample[11:0], zero pad to 16
//
// Voices sit in a ring of cells that rotates once per note on, note off or tick,
// one voice per cycle past a head unit; a tick then drains the mix pipeline
// into the output register.
// A step write is reduced in a compare-subtract reducer; a wave write is stored
// as it is accepted. Reset clears all voices; both tables are unset until
// written. A finished sample waits in the output register; a tick that finishes
// while it is still held stalls until it is taken.
module polyphonic_wavetable_voice_mixer #(
    parameter int VOICE_COUNT = 16,
    parameter int WAVE_SIZE   = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // action, note_number, velocity, table_index, table_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // dac_sample
);
    import pwvm_pkg::*;

    localparam int WAVE_AW   = $clog2(WAVE_SIZE);
    localparam int PHASE_W   = $clog2(WAVE_SIZE) + 16;
    localparam int RED_STEPS = (26 - PHASE_W > 1) ? 26 - PHASE_W : 1;
    localparam int RW        = PHASE_W + RED_STEPS;
    localparam int CNT_W     = $clog2(VOICE_COUNT + 1);
    localparam int RCNT_W    = $clog2(RED_STEPS + 1);
    localparam int SUM_W     = 20 + $clog2(VOICE_COUNT + 1);

    localparam logic [PHASE_W:0] WRAP_P  = (PHASE_W+1)'(WAVE_SIZE) << 16;
    localparam logic [RW-1:0]    DIV_TOP = RW'(WAVE_SIZE) << (16 + RED_STEPS - 1);

    // input fields
    logic [2:0]         in_action;
    logic [NOTE_W-1:0]  in_note;
    logic [VOL_W-1:0]   in_vel;
    logic [11:0]        in_tidx;
    logic [TVAL_W-1:0]  in_tval;
    logic               in_xfer;

    assign in_action = s_axis_tdata[2:0];
    assign in_note   = s_axis_tdata[9:3];
    assign in_vel    = s_axis_tdata[16:10];
    assign in_tidx   = s_axis_tdata[28:17];
    assign in_tval   = s_axis_tdata[54:29];

    state_t state_reg, state_next;
    logic [2:0]        act_reg;
    logic [NOTE_W-1:0] key_reg;
    logic [VOL_W-1:0]  vel_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RCNT_W-1:0] rcnt_reg;
    logic              done_reg;
    logic [RW-1:0]     red_reg, div_reg;
    logic [RW-1:0]     red_next;

    logic [WAVE_W-1:0]  wave_mem [WAVE_SIZE];
    logic [PHASE_W-1:0] step_mem [128];
    logic [WAVE_W-1:0]  wave_rd_reg;
    logic [PHASE_W-1:0] step_rd_reg;

    // tick pipeline
    logic               p1_valid_reg, p2_valid_reg;
    logic [VOL_W-1:0]   p1_vol_reg;
    logic signed [23:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic              out_valid_reg;
    logic [DAC_W-1:0]  out_data_reg;

    // ring
    voice_ctl_t         ctl_q   [VOICE_COUNT];
    logic [PHASE_W-1:0] step_q  [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_q [VOICE_COUNT];
    voice_ctl_t         head_ctl;
    logic [PHASE_W-1:0] head_step, head_phase;
    logic               ring_shift;
    logic               head_take;

    logic [PHASE_W:0]   ph_sum;
    logic [PHASE_W-1:0] ph_new;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign ring_shift    = (state_reg == ST_RUN);

    for (genvar k = 0; k < VOICE_COUNT; k++)
    begin : g_cell
        if (k == VOICE_COUNT - 1)
        begin : g_last
            pwvm_cell #(.PHASE_W(PHASE_W)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(ring_shift),
                .ctl_in(head_ctl), .step_in(head_step), .phase_in(head_phase),
                .ctl_out(ctl_q[k]), .step_out(step_q[k]), .phase_out(phase_q[k])
            );
        end
        else
        begin : g_mid
            pwvm_cell #(.PHASE_W(PHASE_W)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(ring_shift),
                .ctl_in(ctl_q[k+1]), .step_in(step_q[k+1]), .phase_in(phase_q[k+1]),
                .ctl_out(ctl_q[k]), .step_out(step_q[k]), .phase_out(phase_q[k])
            );
        end
    end

    // head unit: voice 0 of the ring is visited in voice order
    assign ph_sum = {1'b0, phase_q[0]} + {1'b0, step_q[0]};
    assign ph_new = (ph_sum >= WRAP_P) ? PHASE_W'(ph_sum - WRAP_P) : ph_sum[PHASE_W-1:0];

    always_comb
    begin
        head_ctl   = ctl_q[0];
        head_step  = step_q[0];
        head_phase = phase_q[0];
        head_take  = 1'b0;
        case (act_reg)
            ACT_TICK:
            begin
                if (ctl_q[0].busy)
                    head_phase = ph_new;
            end
            ACT_NOTE_ON:
            begin
                if (!done_reg && !ctl_q[0].busy)
                begin
                    head_take     = 1'b1;
                    head_ctl.busy = 1'b1;
                    head_ctl.note = key_reg;
                    head_ctl.vol  = vel_reg;
                    head_step     = step_rd_reg;
                    head_phase    = '0;
                end
            end
            ACT_NOTE_OFF:
            begin
                if (!done_reg && ctl_q[0].busy && ctl_q[0].note == key_reg)
                begin
                    head_take     = 1'b1;
                    head_ctl.busy = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign red_next = (red_reg >= div_reg) ? red_reg - div_reg : red_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_action == ACT_TICK || in_action == ACT_NOTE_ON ||
                        in_action == ACT_NOTE_OFF)
                        state_next = ST_RUN;
                    else if (in_action == ACT_STEP_WR)
                        state_next = ST_STEPW;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == CNT_W'(VOICE_COUNT - 1))
                    state_next = (act_reg == ACT_TICK) ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            ST_STEPW:
            begin
                if (rcnt_reg == RCNT_W'(RED_STEPS - 1))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= ACT_WAVE_WR;
            cnt_reg  <= '0;
            rcnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                // zero velocity turns a note on into a note off
                act_reg  <= (in_action == ACT_NOTE_ON && in_vel == '0) ? ACT_NOTE_OFF
                                                                       : in_action;
                cnt_reg  <= '0;
                rcnt_reg <= '0;
                done_reg <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                cnt_reg <= (cnt_reg == CNT_W'(VOICE_COUNT - 1)) ? '0 : cnt_reg + 1'b1;
                if (head_take)
                    done_reg <= 1'b1;
            end
            else if (state_reg == ST_DRAIN)
                cnt_reg <= cnt_reg + 1'b1;
            else if (state_reg == ST_STEPW)
                rcnt_reg <= rcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg <= in_note;
            vel_reg <= in_vel;
            red_reg <= RW'(in_tval[STEP_IN_W-1:0]);
            div_reg <= DIV_TOP;
        end
        else if (state_reg == ST_STEPW)
        begin
            red_reg <= red_next;
            div_reg <= div_reg >> 1;
        end
    end

    // tables
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_action == ACT_WAVE_WR && {1'b0, in_tidx} < 13'(WAVE_SIZE))
            wave_mem[in_tidx[WAVE_AW-1:0]] <= in_tval[WAVE_W-1:0];
        wave_rd_reg <= wave_mem[ph_new[PHASE_W-1:16]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STEPW && rcnt_reg == RCNT_W'(RED_STEPS - 1))
            step_mem[key_reg] <= red_next[PHASE_W-1:0];
        if (in_xfer)
            step_rd_reg <= step_mem[in_note];
    end

    // mix pipeline: wave read, multiply, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ring_shift && act_reg == ACT_TICK && ctl_q[0].busy;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_vol_reg <= ctl_q[0].vol;
        prod_reg   <= $signed(wave_rd_reg) * $signed({1'b0, p1_vol_reg});
        if (in_xfer)
            acc_reg <= '0;
        else if (p2_valid_reg)
            acc_reg <= acc_reg + SUM_W'(prod_reg >>> 4);
    end

    // divide by 1024 toward zero, offset and clamp
    logic signed [SUM_W-1:0] quo, res;
    always_comb
    begin
        quo = (acc_reg < 0) ? (acc_reg + SUM_W'(1023)) >>> 10 : acc_reg >>> 10;
        res = quo + SUM_W'(2048);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && (!out_valid_reg || m_axis_tready))
        begin
            if (res < 0)
                out_data_reg <= '0;
            else if (res > SUM_W'(4095))
                out_data_reg <= 12'd4095;
            else
                out_data_reg <= res[DAC_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

endmodule

// ----- tb/sv/tb_polyphonic_wavetable_voice_mixer.sv -----
module tb_polyphonic_wavetable_voice_mixer;
    import pwvm_pkg::*;

    localparam int VOICES = 16;
    localparam int WAVE_LEN = 512;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    class mixer_scoreboard;
        bit                     busy [VOICES];
        logic [NOTE_W-1:0]      key [VOICES];
        logic [VOL_W-1:0]       vol [VOICES];
        logic [STEP_IN_W-1:0]   incr [VOICES];
        logic [27:0]            phase [VOICES];
        logic signed [WAVE_W-1:0] wave [WAVE_LEN];
        logic [STEP_IN_W-1:0]   note_incr [128];
        logic [DAC_W-1:0]       dac_expected [$];
        int                     errors;

        function new();
            errors = 0;
            for (int v = 0; v < VOICES; v++)
            begin
                busy[v] = 0;
                key[v] = 0;
                vol[v] = 0;
                incr[v] = 0;
                phase[v] = 0;
            end
        endfunction

        function void release_key(logic [NOTE_W-1:0] k);
            for (int v = 0; v < VOICES; v++)
            begin
                if (busy[v] && key[v] == k)
                begin
                    busy[v] = 0;
                    return;
                end
            end
        endfunction

        function void note_input(logic [2:0] act, logic [NOTE_W-1:0] k,
                                 logic [VOL_W-1:0] vel, logic [11:0] idx,
                                 logic [TVAL_W-1:0] val);
            int sum;
            int prod;
            logic [31:0] ph;
            case (act)
                ACT_TICK:
                begin
                    sum = 0;
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (busy[v])
                        begin
                            ph = ({4'd0, phase[v]} + {7'd0, incr[v]}) % (WAVE_LEN << 16);
                            phase[v] = ph[27:0];
                            prod = int'(wave[ph >> 16]) * int'({1'b0, vol[v]});
                            sum += prod >>> 4;
                        end
                    end
                    sum = sum / 1024 + 2048;
                    if (sum > 4095)
                        sum = 4095;
                    else if (sum < 0)
                        sum = 0;
                    dac_expected.push_back(sum[DAC_W-1:0]);
                end
                ACT_NOTE_ON:
                begin
                    if (vel == 0)
                        release_key(k);
                    else
                    begin
                        for (int v = 0; v < VOICES; v++)
                        begin
                            if (!busy[v])
                            begin
                                key[v] = k;
                                incr[v] = note_incr[k];
                                phase[v] = 0;
                                vol[v] = vel;
                                busy[v] = 1;
                                break;
                            end
                        end
                    end
                end
                ACT_NOTE_OFF: release_key(k);
                ACT_WAVE_WR:
                    if (idx < WAVE_LEN)
                        wave[idx] = val[WAVE_W-1:0];
                ACT_STEP_WR: note_incr[k] = val[STEP_IN_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_result(logic [DAC_W-1:0] got);
            logic [DAC_W-1:0] exp_val;
            if (dac_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
                return;
            end
            exp_val = dac_expected.pop_front();
            if (got !== exp_val)
            begin
                errors++;
                $display("%0t: dac_sample mismatch, expected %0d, actual %0d",
                         $time, exp_val, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    mixer_scoreboard sb;
    bit no_idle;
    int idle_cycles;

    polyphonic_wavetable_voice_mixer uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send(logic [2:0] act, logic [NOTE_W-1:0] k, logic [VOL_W-1:0] vel,
                        logic [11:0] idx, logic [TVAL_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, val, idx, vel, k, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(act, k, vel, idx, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.dac_expected.size() != 0)
            @(posedge clk);
    endtask

    // sink side
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[DAC_W-1:0]);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int r;
        logic [NOTE_W-1:0] k;
        logic [TVAL_W-1:0] v;
        sb = new();
        no_idle = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load both tables so that every tick reads written entries only
        for (int i = 0; i < WAVE_LEN; i++)
            send(ACT_WAVE_WR, 7'($urandom), 7'($urandom), 12'(i), 26'($urandom));
        for (int i = 0; i < 128; i++)
        begin
            v = (i % 4 == 0) ? 26'($urandom) : 26'($urandom_range(0, 3 << 16));
            send(ACT_STEP_WR, 7'(i), 7'($urandom), 12'($urandom), v);
        end

        // directed
        send(ACT_TICK, 0, 0, 0, 0);
        send(ACT_NOTE_ON, 7'd0, 7'd127, 0, 0);
        send(ACT_NOTE_ON, 7'd127, 7'd1, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0);
        send(ACT_NOTE_ON, 7'd0, 7'd0, 0, 0);       // zero velocity releases
        send(ACT_NOTE_OFF, 7'd5, 0, 0, 0);         // no such voice
        send(ACT_NOTE_OFF, 7'd127, 0, 0, 0);
        send(ACT_WAVE_WR, 0, 0, 12'd4095, 26'h3FFFFFF);  // out of range, dropped
        send(ACT_WAVE_WR, 0, 0, 12'd512, 26'd0);
        send(ACT_STEP_WR, 7'd127, 0, 0, 26'h1FFFFFF);
        send(ACT_RSVD5, 7'd127, 7'd127, 12'd4095, 26'h3FFFFFF);
        send(ACT_RSVD6, 0, 0, 0, 0);
        send(ACT_RSVD7, 0, 0, 0, 0);
        send(ACT_NOTE_ON, 7'd127, 7'd64, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0);
        send(ACT_NOTE_OFF, 7'd127, 0, 0, 0);
        // all voices on a still phase at full scale: clamps both ways
        send(ACT_STEP_WR, 7'd10, 0, 0, 26'd0);
        send(ACT_WAVE_WR, 0, 0, 12'd0, 26'd32767);
        for (int i = 0; i <= VOICES; i++)
            send(ACT_NOTE_ON, 7'd10, 7'd127, 0, 0);   // last one finds no free voice
        send(ACT_TICK, 0, 0, 0, 0);
        send(ACT_WAVE_WR, 0, 0, 12'd0, 26'h3FF8000);  // -32768
        send(ACT_TICK, 0, 0, 0, 0);
        for (int i = 0; i < VOICES; i++)
            send(ACT_NOTE_OFF, 7'd10, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0);
        drain();

        // random
        for (int n = 0; n < 600; n++)
        begin
            if (n % 100 == 0)
                no_idle = (n % 200 == 100);
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
            if (r < 40)
                send(ACT_TICK, 7'($urandom), 7'($urandom), 12'($urandom), 26'($urandom));
            else if (r < 65)
                send(ACT_NOTE_ON, k,
                     ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom),
                     12'($urandom), 26'($urandom));
            else if (r < 85)
                send(ACT_NOTE_OFF, k, 7'($urandom), 12'($urandom), 26'($urandom));
            else if (r < 93)
                send(ACT_WAVE_WR, 7'($urandom), 7'($urandom),
                     ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 511)),
                     26'($urandom));
            else if (r < 98)
                send(ACT_STEP_WR, 7'($urandom), 7'($urandom), 12'($urandom), 26'($urandom));
            else
                send(3'($urandom_range(5, 7)), 7'($urandom), 7'($urandom),
                     12'($urandom), 26'($urandom));
        end
        drain();
        repeat (100) @(posedge clk);

        if (sb.dac_expected.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d samples never arrived", $time, sb.dac_expected.size());
        end
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pwvm_pkg.sv
design/pwvm_cell.sv
design/polyphonic_wavetable_voice_mixer.sv
tb/sv/tb_polyphonic_wavetable_voice_mixer.sv
